>>> rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master transaction sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int COUNT_BITS_DEF = 16;

    // Command kinds on the input channel
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_EVENT = 1'b1;

    // Engine status codes (low three bits masked)
    localparam logic [7:0] STATUS_MASK       = 8'hF8;
    localparam logic [7:0] ST_START          = 8'h08;
    localparam logic [7:0] ST_RESTART        = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK     = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK    = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK    = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK   = 8'h30;
    localparam logic [7:0] ST_ARB_LOST       = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK     = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK    = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK    = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK   = 8'h58;

    localparam logic [7:0] ADDR_DIR_MASK     = 8'hFE;

    // Subaddress kinds
    localparam logic [1:0] SUB_NONE  = 2'd0;
    localparam logic [1:0] SUB_ONE   = 2'd1;
    localparam logic [1:0] SUB_TWO   = 2'd2;
    localparam logic [1:0] SUB_EIGHT = 2'd3;

    typedef enum logic [1:0] {
        PH_DIRECT    = 2'd0,
        PH_SUB_READ  = 2'd1,
        PH_SUB_WRITE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        RES_BUSY   = 2'd0,
        RES_DONE   = 2'd1,
        RES_ERROR  = 2'd2,
        RES_REJECT = 2'd3
    } t_result;

    typedef enum logic [1:0] {
        ACK_KEEP  = 2'd0,
        ACK_SET   = 2'd1,
        ACK_CLEAR = 2'd2
    } t_ack;

    typedef struct packed {
        logic       load_data;
        logic [7:0] data_out;
        logic       send_start;
        logic       send_stop;
        t_ack       ack_control;
        logic       clear_event;
        logic       tx_consumed;
        logic       rx_valid;
        logic [7:0] rx_out;
        t_result    result_code;
    } t_ctrl_out;

endpackage

>>> rtl/i2c_master_transaction_sequencer_core.sv
// Top level: I2C master transfer sequencer driven by start commands and engine events.
`timescale 1ns / 1ps

//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-----------------------------------------
//  in      | i_in_valid  | o_in_stall   | i_action .. i_tx_byte (command or event)
//  out     | o_out_valid | i_out_stall  | o_load_data .. o_result_code
//
// One transaction per cycle while the output is not stalled: the decode of the
// command or status event is a single combinational pass from the input ports to
// the output register, and the sequencer state updates on the same edge.
// Reset clears the sequencer state and empties the output register.
// The input stalls only while the output register is full and itself stalled.

module i2c_master_transaction_sequencer_core #(
    parameter int COUNT_BITS = i2cms_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [7:0]            i_dev_addr,
    input  logic                  i_read_not_write,
    input  logic [1:0]            i_subaddr_kind,
    input  logic [15:0]           i_sub_address,
    input  logic [15:0]           i_byte_count,
    input  logic [7:0]            i_status_code,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_tx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_load_data,
    output logic [7:0]            o_data_out,
    output logic                  o_send_start,
    output logic                  o_send_stop,
    output logic [1:0]            o_ack_control,
    output logic                  o_clear_event,
    output logic                  o_tx_consumed,
    output logic                  o_rx_valid,
    output logic [7:0]            o_rx_out,
    output logic [1:0]            o_result_code
);
    import i2cms_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    t_phase                r_phase,     n_phase;
    logic [7:0]            r_target,    n_target;
    logic [15:0]           r_reg_addr,  n_reg_addr;
    logic [1:0]            r_reg_left,  n_reg_left;
    logic [COUNT_BITS-1:0] r_data_left, n_data_left;
    t_result               r_end,       n_end;

    logic                  r_out_valid;
    t_ctrl_out             r_out,       n_out;

    logic                  accept;
    logic [7:0]            st;
    logic [COUNT_BITS-1:0] cnt_sat;
    logic [COUNT_BITS-1:0] dl_dec;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign st         = i_status_code & STATUS_MASK;
    assign cnt_sat    = (32'(i_byte_count) > 32'(CNT_MAX)) ? CNT_MAX
                                                           : COUNT_BITS'(i_byte_count);
    assign dl_dec     = (r_data_left != '0) ? r_data_left - CNT_ONE : r_data_left;

    always_comb begin
        n_phase     = r_phase;
        n_target    = r_target;
        n_reg_addr  = r_reg_addr;
        n_reg_left  = r_reg_left;
        n_data_left = r_data_left;
        n_end       = r_end;
        n_out       = '0;

        if (i_action == ACT_START) begin
            if (i_byte_count == 16'd0) begin
                n_out.result_code = RES_REJECT;
            end else begin
                n_reg_addr = i_sub_address;
                unique case (i_subaddr_kind)
                    SUB_NONE: n_reg_left = 2'd0;
                    SUB_TWO:  n_reg_left = 2'd2;
                    default:  n_reg_left = 2'd1;
                endcase
                if (i_subaddr_kind == SUB_EIGHT) begin
                    // high subaddress bits fold into the device address
                    n_target   = i_dev_addr + {4'b0, i_sub_address[10:8], 1'b0}
                               + {7'b0, i_read_not_write};
                    n_reg_addr = {8'b0, i_sub_address[7:0]};
                end else begin
                    n_target = i_dev_addr + {7'b0, i_read_not_write};
                end
                if (i_subaddr_kind == SUB_NONE) begin
                    n_phase = PH_DIRECT;
                end else begin
                    n_phase = i_read_not_write ? PH_SUB_READ : PH_SUB_WRITE;
                end
                n_data_left       = cnt_sat;
                n_end             = RES_BUSY;
                n_out.send_start  = 1'b1;
                n_out.ack_control = ACK_CLEAR;
                n_out.clear_event = 1'b1;
                n_out.result_code = RES_BUSY;
            end
        end else begin
            unique case (st) inside
                ST_START: begin
                    n_out.load_data   = 1'b1;
                    n_out.clear_event = 1'b1;
                    // subaddressed reads open with write direction
                    n_out.data_out    = (r_phase == PH_SUB_READ) ? (r_target & ADDR_DIR_MASK)
                                                                 : r_target;
                end
                ST_RESTART: begin
                    n_out.load_data   = 1'b1;
                    n_out.clear_event = 1'b1;
                    n_out.data_out    = r_target;
                end
                ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                    unique case (r_phase)
                        PH_DIRECT: begin
                            if (r_data_left != '0) begin
                                n_out.load_data   = 1'b1;
                                n_out.clear_event = 1'b1;
                                n_out.data_out    = i_tx_byte;
                                n_out.tx_consumed = 1'b1;
                                n_data_left       = r_data_left - CNT_ONE;
                            end else begin
                                n_out.send_stop   = 1'b1;
                                n_out.clear_event = 1'b1;
                                n_end             = RES_DONE;
                            end
                        end
                        PH_SUB_READ, PH_SUB_WRITE: begin
                            if (r_reg_left == 2'd2) begin
                                n_out.load_data   = 1'b1;
                                n_out.clear_event = 1'b1;
                                n_out.data_out    = r_reg_addr[15:8];
                                n_reg_left        = 2'd1;
                            end else if (r_reg_left == 2'd1) begin
                                n_out.load_data   = 1'b1;
                                n_out.clear_event = 1'b1;
                                n_out.data_out    = r_reg_addr[7:0];
                                n_reg_left        = 2'd0;
                                if (r_phase == PH_SUB_WRITE) begin
                                    n_phase = PH_DIRECT;
                                end
                            end else if (r_reg_left == 2'd0 && r_phase == PH_SUB_READ) begin
                                // subaddress sent: repeated start for the read
                                n_out.send_start  = 1'b1;
                                n_out.clear_event = 1'b1;
                                n_phase           = PH_DIRECT;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_MR_SLA_ACK: begin
                    n_out.ack_control = (r_data_left <= CNT_ONE) ? ACK_CLEAR : ACK_SET;
                    n_out.clear_event = 1'b1;
                end
                ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_ARB_LOST, ST_MR_SLA_NACK: begin
                    n_out.clear_event = 1'b1;
                    n_end             = RES_ERROR;
                end
                ST_MR_DATA_ACK: begin
                    n_out.rx_valid    = 1'b1;
                    n_out.rx_out      = i_rx_byte;
                    n_data_left       = dl_dec;
                    // NACK the last byte
                    n_out.ack_control = (dl_dec == CNT_ONE) ? ACK_CLEAR : ACK_SET;
                    n_out.clear_event = 1'b1;
                end
                ST_MR_DATA_NACK: begin
                    n_out.rx_valid    = 1'b1;
                    n_out.rx_out      = i_rx_byte;
                    n_out.send_stop   = 1'b1;
                    n_out.clear_event = 1'b1;
                    n_end             = RES_DONE;
                end
                default: ;
            endcase
            n_out.result_code = n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DIRECT;
            r_target    <= '0;
            r_reg_addr  <= '0;
            r_reg_left  <= '0;
            r_data_left <= '0;
            r_end       <= RES_BUSY;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_target    <= n_target;
                r_reg_addr  <= n_reg_addr;
                r_reg_left  <= n_reg_left;
                r_data_left <= n_data_left;
                r_end       <= n_end;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_load_data   = r_out.load_data;
    assign o_data_out    = r_out.data_out;
    assign o_send_start  = r_out.send_start;
    assign o_send_stop   = r_out.send_stop;
    assign o_ack_control = r_out.ack_control;
    assign o_clear_event = r_out.clear_event;
    assign o_tx_consumed = r_out.tx_consumed;
    assign o_rx_valid    = r_out.rx_valid;
    assign o_rx_out      = r_out.rx_out;
    assign o_result_code = r_out.result_code;

endmodule

>>> dv/i2c_master_transaction_sequencer_core_tb.sv
// Self-checking testbench for the I2C master transaction sequencer core.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_core_tb;
    import i2cms_pkg::*;

    localparam logic [7:0] EXT_ADDR_MASK = 8'h0E;
    localparam int RAND_ITEMS = 950;
    localparam int IDLE_PCT   = 27;

    typedef struct {
        logic        action;
        logic [7:0]  dev;
        logic        rd;
        logic [1:0]  kind;
        logic [15:0] sub;
        logic [15:0] count;
        logic [7:0]  status;
        logic [7:0]  rx;
        logic [7:0]  tx;
        bit          drain;
    } bus_item_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [7:0]  i_dev_addr;
    logic        i_read_not_write;
    logic [1:0]  i_subaddr_kind;
    logic [15:0] i_sub_address;
    logic [15:0] i_byte_count;
    logic [7:0]  i_status_code;
    logic [7:0]  i_rx_byte;
    logic [7:0]  i_tx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_load_data;
    logic [7:0]  o_data_out;
    logic        o_send_start;
    logic        o_send_stop;
    logic [1:0]  o_ack_control;
    logic        o_clear_event;
    logic        o_tx_consumed;
    logic        o_rx_valid;
    logic [7:0]  o_rx_out;
    logic [1:0]  o_result_code;

    i2c_master_transaction_sequencer_core u_top (.*);

    // sequencer shadow state
    t_phase      seq_phase;
    logic [7:0]  seq_target;
    logic [15:0] seq_reg_addr;
    logic [1:0]  seq_reg_left;
    logic [15:0] seq_data_left;
    t_result     seq_end;

    bus_item_t   cmd_q[$];
    t_ctrl_out   ctrl_expect_q[$];
    int          n_queued;
    int          n_accepted;
    int          n_errors;
    bit          in_taken;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic load_byte(inout t_ctrl_out r, input logic [7:0] b);
        r.load_data   = 1'b1;
        r.data_out    = b;
        r.clear_event = 1'b1;
    endtask

    task automatic load_reg_byte(inout t_ctrl_out r);
        if (seq_reg_left == 2'd2) begin
            load_byte(r, seq_reg_addr[15:8]);
            seq_reg_left = 2'd1;
        end else begin
            load_byte(r, seq_reg_addr[7:0]);
            seq_reg_left = 2'd0;
        end
    endtask

    task automatic sequence_step(input bus_item_t it, output t_ctrl_out r);
        logic [7:0] st;
        st = it.status & STATUS_MASK;
        r = '0;
        if (it.action == ACT_START) begin
            if (it.count == 16'd0) begin
                r.result_code = RES_REJECT;
            end else begin
                seq_reg_addr = it.sub;
                seq_reg_left = (it.kind == SUB_TWO) ? 2'd2 : (it.kind == SUB_NONE ? 2'd0 : 2'd1);
                if (it.kind == SUB_EIGHT) begin
                    // high subaddress bits fold into the device address
                    seq_target = it.dev + (it.sub[14:7] & EXT_ADDR_MASK) + 8'(it.rd);
                    seq_reg_addr = {8'd0, it.sub[7:0]};
                end else begin
                    seq_target = it.dev + 8'(it.rd);
                end
                seq_phase = (it.kind == SUB_NONE) ? PH_DIRECT : (it.rd ? PH_SUB_READ : PH_SUB_WRITE);
                seq_data_left = it.count;
                seq_end = RES_BUSY;
                r.send_start  = 1'b1;
                r.ack_control = ACK_CLEAR;
                r.clear_event = 1'b1;
                r.result_code = seq_end;
            end
        end else begin
            case (st)
                ST_START: begin
                    load_byte(r, seq_phase == PH_SUB_READ ? (seq_target & ADDR_DIR_MASK)
                                                          : seq_target);
                end
                ST_RESTART: begin
                    load_byte(r, seq_target);
                end
                ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                    case (seq_phase)
                        PH_DIRECT: begin
                            if (seq_data_left > 0) begin
                                load_byte(r, it.tx);
                                r.tx_consumed = 1'b1;
                                seq_data_left--;
                            end else begin
                                r.send_stop   = 1'b1;
                                r.clear_event = 1'b1;
                                seq_end = RES_DONE;
                            end
                        end
                        PH_SUB_READ: begin
                            if (seq_reg_left == 2'd1 || seq_reg_left == 2'd2) begin
                                load_reg_byte(r);
                            end else if (seq_reg_left == 2'd0) begin
                                // subaddress sent: repeated start for the read
                                r.send_start  = 1'b1;
                                r.clear_event = 1'b1;
                                seq_phase = PH_DIRECT;
                            end
                        end
                        PH_SUB_WRITE: begin
                            if (seq_reg_left == 2'd1 || seq_reg_left == 2'd2) begin
                                load_reg_byte(r);
                                if (seq_reg_left == 2'd0) seq_phase = PH_DIRECT;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_MR_SLA_ACK: begin
                    r.ack_control = (seq_data_left <= 1) ? ACK_CLEAR : ACK_SET;
                    r.clear_event = 1'b1;
                end
                ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_ARB_LOST, ST_MR_SLA_NACK: begin
                    r.clear_event = 1'b1;
                    seq_end = RES_ERROR;
                end
                ST_MR_DATA_ACK: begin
                    r.rx_valid = 1'b1;
                    r.rx_out   = it.rx;
                    if (seq_data_left > 0) seq_data_left--;
                    r.ack_control = (seq_data_left == 1) ? ACK_CLEAR : ACK_SET;
                    r.clear_event = 1'b1;
                end
                ST_MR_DATA_NACK: begin
                    r.rx_valid    = 1'b1;
                    r.rx_out      = it.rx;
                    r.send_stop   = 1'b1;
                    r.clear_event = 1'b1;
                    seq_end = RES_DONE;
                end
                default: ;
            endcase
            r.result_code = seq_end;
        end
    endtask

    function automatic bus_item_t random_item();
        bus_item_t it;
        it.action = 1'($urandom);
        it.dev    = 8'($urandom);
        it.rd     = 1'($urandom);
        it.kind   = 2'($urandom);
        it.sub    = 16'($urandom);
        it.count  = 16'($urandom);
        it.status = 8'($urandom);
        it.rx     = 8'($urandom);
        it.tx     = 8'($urandom);
        it.drain  = 1'b0;
        return it;
    endfunction

    task automatic push_start(input logic [7:0] dev, input logic rd, input logic [1:0] kind,
                              input logic [15:0] sub, input logic [15:0] cnt, input bit drain);
        bus_item_t it;
        it = random_item();
        it.action = ACT_START;
        it.dev    = dev;
        it.rd     = rd;
        it.kind   = kind;
        it.sub    = sub;
        it.count  = cnt;
        it.drain  = drain;
        cmd_q.push_back(it);
        n_queued++;
    endtask

    // low three status bits are don't-care, so they get random values
    task automatic push_event(input logic [7:0] code, input logic [7:0] rx, input logic [7:0] tx);
        bus_item_t it;
        it = random_item();
        it.action = ACT_EVENT;
        it.status = code | 8'($urandom_range(0, 7));
        it.rx     = rx;
        it.tx     = tx;
        cmd_q.push_back(it);
        n_queued++;
    endtask

    // one well-formed transfer, sometimes cut short by a bus error
    task automatic gen_transfer(input bit drain);
        logic [7:0]  codes[$];
        logic [7:0]  dev;
        logic [15:0] sub;
        logic [15:0] cnt;
        logic [1:0]  kind;
        logic        rd;
        int          nsub;
        int          nbytes;
        int          cut;
        dev  = 8'($urandom);
        rd   = 1'($urandom);
        kind = 2'($urandom);
        sub  = 16'($urandom);
        cnt  = ($urandom_range(0, 99) < 10) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 5));
        nsub = (kind == SUB_NONE) ? 0 : (kind == SUB_TWO ? 2 : 1);
        nbytes = (cnt > 6) ? $urandom_range(1, 6) : int'(cnt);
        if (rd && $urandom_range(0, 99) < 10) nbytes += 2;
        push_start(dev, rd, kind, sub, cnt, drain);
        codes.push_back(ST_START);
        if (rd) begin
            if (kind != SUB_NONE) begin
                codes.push_back(ST_MT_SLA_ACK);
                repeat (nsub) codes.push_back(ST_MT_DATA_ACK);
                codes.push_back(ST_RESTART);
            end
            codes.push_back(ST_MR_SLA_ACK);
            repeat (nbytes - 1) codes.push_back(ST_MR_DATA_ACK);
            codes.push_back(ST_MR_DATA_NACK);
        end else begin
            codes.push_back(ST_MT_SLA_ACK);
            repeat (nsub + nbytes) codes.push_back(ST_MT_DATA_ACK);
        end
        if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, codes.size() - 1);
            codes = codes[0:cut-1];
            case ($urandom_range(0, 3))
                0: codes.push_back(ST_MT_SLA_NACK);
                1: codes.push_back(ST_MT_DATA_NACK);
                2: codes.push_back(ST_ARB_LOST);
                default: codes.push_back(ST_MR_SLA_NACK);
            endcase
        end
        foreach (codes[i]) push_event(codes[i], 8'($urandom), 8'($urandom));
    endtask

    task automatic fill_stimulus();
        bus_item_t it;
        // zero count is rejected, then an event from the reset state
        push_start(8'hFF, 1'b1, SUB_TWO, 16'hFFFF, 16'd0, 1'b0);
        push_event(ST_START, 8'h00, 8'h00);
        // eight-plus-X read whose address sum wraps, full count
        push_start(8'hFF, 1'b1, SUB_EIGHT, 16'hFFFF, 16'hFFFF, 1'b0);
        push_event(ST_START, 8'h00, 8'hFF);
        push_event(ST_MT_SLA_ACK, 8'h00, 8'h00);
        push_event(ST_MT_DATA_ACK, 8'h00, 8'h00);
        push_event(ST_RESTART, 8'h00, 8'h00);
        push_event(ST_MR_SLA_ACK, 8'h00, 8'h00);
        push_event(ST_MR_DATA_ACK, 8'hFF, 8'h00);
        push_event(ST_MR_DATA_NACK, 8'h00, 8'h00);
        // two-byte subaddress write of a single byte
        push_start(8'h00, 1'b0, SUB_TWO, 16'hA55A, 16'd1, 1'b0);
        push_event(ST_START, 8'h00, 8'h00);
        push_event(ST_MT_SLA_ACK, 8'h00, 8'h00);
        push_event(ST_MT_DATA_ACK, 8'h00, 8'h00);
        push_event(ST_MT_DATA_ACK, 8'h00, 8'hFF);
        push_event(ST_MT_DATA_ACK, 8'h00, 8'h00);
        // unhandled status and every error status
        push_event(8'hF8, 8'hFF, 8'hFF);
        push_event(8'h00, 8'h00, 8'h00);
        push_event(ST_MT_SLA_NACK, 8'h00, 8'h00);
        push_event(ST_MT_DATA_NACK, 8'h00, 8'h00);
        push_event(ST_ARB_LOST, 8'h00, 8'h00);
        push_event(ST_MR_SLA_NACK, 8'h00, 8'h00);
        n_queued = 0;
        gen_transfer(1'b1);
        while (n_queued < RAND_ITEMS) begin
            if ($urandom_range(0, 99) < 12) begin
                it = random_item();
                if (it.action == ACT_START && $urandom_range(0, 3) == 0) it.count = 16'd0;
                // one drained pause halfway through
                it.drain = (n_queued > RAND_ITEMS / 2 && n_queued < RAND_ITEMS / 2 + 3);
                cmd_q.push_back(it);
                n_queued++;
            end else begin
                gen_transfer(1'b0);
            end
        end
    endtask

    function automatic bit calm_stretch();
        return n_accepted >= 300 && n_accepted < 550;
    endfunction

    // input driver and output stall, both on the falling edge
    always @(negedge i_clk) begin
        bus_item_t it;
        if (i_rst_n) begin
            if (in_taken || !i_in_valid) begin
                if (cmd_q.size() > 0 && !(cmd_q[0].drain && ctrl_expect_q.size() > 0) &&
                    (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    it = cmd_q.pop_front();
                    i_action         <= it.action;
                    i_dev_addr       <= it.dev;
                    i_read_not_write <= it.rd;
                    i_subaddr_kind   <= it.kind;
                    i_sub_address    <= it.sub;
                    i_byte_count     <= it.count;
                    i_status_code    <= it.status;
                    i_rx_byte        <= it.rx;
                    i_tx_byte        <= it.tx;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            in_taken = 1'b0;
            i_out_stall <= !calm_stretch() && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // monitor: check results, then predict for the transaction taken at this edge
    always @(posedge i_clk) begin
        t_ctrl_out exp_r;
        bus_item_t it;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (ctrl_expect_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual data_out %0h",
                             $time, o_data_out);
                    n_errors++;
                end else begin
                    exp_r = ctrl_expect_q.pop_front();
                    check_field("load_data",   exp_r.load_data,   o_load_data);
                    check_field("data_out",    exp_r.data_out,    o_data_out);
                    check_field("send_start",  exp_r.send_start,  o_send_start);
                    check_field("send_stop",   exp_r.send_stop,   o_send_stop);
                    check_field("ack_control", exp_r.ack_control, o_ack_control);
                    check_field("clear_event", exp_r.clear_event, o_clear_event);
                    check_field("tx_consumed", exp_r.tx_consumed, o_tx_consumed);
                    check_field("rx_valid",    exp_r.rx_valid,    o_rx_valid);
                    check_field("rx_out",      exp_r.rx_out,      o_rx_out);
                    check_field("result_code", exp_r.result_code, o_result_code);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                it.action = i_action;
                it.dev    = i_dev_addr;
                it.rd     = i_read_not_write;
                it.kind   = i_subaddr_kind;
                it.sub    = i_sub_address;
                it.count  = i_byte_count;
                it.status = i_status_code;
                it.rx     = i_rx_byte;
                it.tx     = i_tx_byte;
                it.drain  = 1'b0;
                sequence_step(it, exp_r);
                ctrl_expect_q.push_back(exp_r);
                in_taken = 1'b1;
                n_accepted++;
            end
        end
    end

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_out_stall      = 1'b0;
        i_action         = 1'b0;
        i_dev_addr       = '0;
        i_read_not_write = 1'b0;
        i_subaddr_kind   = '0;
        i_sub_address    = '0;
        i_byte_count     = '0;
        i_status_code    = '0;
        i_rx_byte        = '0;
        i_tx_byte        = '0;
        in_taken         = 1'b0;
        n_accepted       = 0;
        n_errors         = 0;
        seq_phase        = PH_DIRECT;
        seq_target       = '0;
        seq_reg_addr     = '0;
        seq_reg_left     = '0;
        seq_data_left    = '0;
        seq_end          = RES_BUSY;
        fill_stimulus();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (cmd_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (ctrl_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (ctrl_expect_q.size() != 0) begin
            $display("%0t ns: %0d results missing, expected 0 pending, actual %0d",
                     $time, ctrl_expect_q.size(), ctrl_expect_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
